[rtl/core/dynamic_range_processor_defines.svh]
// Assertion macros shared by the RTL.
`ifndef DYNAMIC_RANGE_PROCESSOR_DEFINES_SVH
`define DYNAMIC_RANGE_PROCESSOR_DEFINES_SVH

// Check that a condition implies a consequence on the same edge.
`define DRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define DRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/drp_pkg.sv]
`timescale 1ns / 1ps
package drp_pkg;

  localparam int SmoothTaps = 150;
  localparam int SampleBits = 16;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 17;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GATE     = 3'd0,
    CFG_EXPAND   = 3'd1,
    CFG_COMPRESS = 3'd2,
    CFG_LIMIT    = 3'd3,
    CFG_ATTACK   = 3'd4,
    CFG_RELEASE  = 3'd5,
    CFG_EXP_SLP  = 3'd6,
    CFG_CMP_SLP  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] gate_th;
    logic signed [15:0] expand_th;
    logic signed [15:0] compress_th;
    logic signed [15:0] limit_th;
    logic [16:0]        attack;
    logic [16:0]        release_c;
    logic signed [15:0] expand_slope;
    logic signed [15:0] compress_slope;
  } cfg_t;

  localparam logic [16:0] OneQ16 = 17'd65536;

  typedef enum logic [3:0] {
    FS_IDLE, FS_PEAK_MUL, FS_PEAK_SUM, FS_NORM, FS_LOG, FS_DB, FS_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    BS_IDLE, BS_ZONE, BS_ZMUL, BS_OCT, BS_INTERP, BS_LIN, BS_HIST_RD,
    BS_HIST_UPD, BS_DIV, BS_OUT_MUL, BS_OUT_RND, BS_DONE
  } back_state_e;

  function automatic logic [16:0] exp2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55110;
      5'd5:  v = 17'd52774;
      5'd6:  v = 17'd50536;
      5'd7:  v = 17'd48394;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/dynamic_range_processor.sv]
`timescale 1ns / 1ps
// Flow: the front (peak follower, 16-step log loop) hands each sample to the queue, then
// the back runs its 10 steps. full is high while the front is busy, so the front takes
// no new sample before the last one has been handed to the queue.
// A result left waiting holds the back in its last step; then the queue fills and full rises.
// Reset (rst_ni low, async): peak at full scale, gain history and sum cleared,
// registers back to defaults, queue and result slot empty.
module dynamic_range_processor #(
  parameter int SampleBits = drp_pkg::SampleBits,
  parameter int SmoothTaps = drp_pkg::SmoothTaps
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic signed [SampleBits-1:0]      sample_in_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [SampleBits-1:0]      sample_out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [drp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [drp_pkg::CfgDataW-1:0]      cfg_data_i
);
  drp_pkg::cfg_t cfg_q;
  logic f_valid, f_ready, b_valid, b_ready;
  logic signed [SampleBits-1:0] f_sample, b_sample;
  logic signed [15:0] f_level, b_level;
  logic [16:0] coef;

  assign cfg_ready_o = 1'b1;
  assign coef = (cfg_data_i > drp_pkg::OneQ16) ? drp_pkg::OneQ16 : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gate_th <= -16'sd11520;
      cfg_q.expand_th <= -16'sd7680;
      cfg_q.compress_th <= -16'sd2560;
      cfg_q.limit_th <= 16'sd0;
      cfg_q.attack <= 17'd49152;
      cfg_q.release_c <= 17'd32768;
      cfg_q.expand_slope <= -16'sd12288;
      cfg_q.compress_slope <= 16'sd3072;
    end else if (cfg_valid_i) begin
      case (drp_pkg::cfg_idx_e'(cfg_index_i))
        drp_pkg::CFG_GATE:     cfg_q.gate_th <= cfg_data_i[15:0];
        drp_pkg::CFG_EXPAND:   cfg_q.expand_th <= cfg_data_i[15:0];
        drp_pkg::CFG_COMPRESS: cfg_q.compress_th <= cfg_data_i[15:0];
        drp_pkg::CFG_LIMIT:    cfg_q.limit_th <= cfg_data_i[15:0];
        drp_pkg::CFG_ATTACK:   cfg_q.attack <= coef;
        drp_pkg::CFG_RELEASE:  cfg_q.release_c <= coef;
        drp_pkg::CFG_EXP_SLP:  cfg_q.expand_slope <= cfg_data_i[15:0];
        drp_pkg::CFG_CMP_SLP:  cfg_q.compress_slope <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  drp_front #(.SampleBits(SampleBits)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .push_i(push), .full_o(full),
    .sample_i(sample_in_i), .q_valid_o(f_valid), .q_ready_i(f_ready),
    .q_sample_o(f_sample), .q_level_o(f_level)
  );

  drp_queue #(.Width(SampleBits + 16)) u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .wr_data_i({f_sample, f_level}), .rd_valid_o(b_valid), .rd_ready_i(b_ready),
    .rd_data_o({b_sample, b_level})
  );

  drp_back #(.SampleBits(SampleBits), .SmoothTaps(SmoothTaps)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(b_valid), .q_ready_o(b_ready),
    .q_sample_i(b_sample), .q_level_i(b_level), .empty_o(empty), .pop_i(pop),
    .sample_out_o(sample_out_o)
  );
endmodule

[rtl/core/drp_front.sv]
`timescale 1ns / 1ps
// Peak follower and level detector: produces (sample, level) pairs.
module drp_front #(
  parameter int SampleBits = drp_pkg::SampleBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  drp_pkg::cfg_t                cfg_i,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic signed [SampleBits-1:0] sample_i,
  output logic                         q_valid_o,
  input  logic                         q_ready_i,
  output logic signed [SampleBits-1:0] q_sample_o,
  output logic signed [15:0]           q_level_o
);
  localparam int PW = SampleBits + 1;
  localparam int EW = $clog2(PW);

  drp_pkg::front_state_e state_q, state_d;
  logic signed [SampleBits-1:0] x_q;
  logic [PW-1:0] a_q, peak_q, peak_d;
  logic [16:0] w_q;
  logic [PW+16:0] pa_q, pb_q;
  logic [EW-1:0] e_q;
  logic [16:0] m_q;
  logic [15:0] frac_q;
  logic [4:0] it_q;
  logic [EW-1:0] e_c;
  logic [16:0] w_c;
  logic [33:0] sq;
  logic [16:0] msq;
  logic [EW+16:0] neg;
  logic [EW+16+20:0] prod;
  logic [EW+16+20:0] dbm;
  logic signed [15:0] lvl_q;
  logic [PW-1:0] a_c;

  assign a_c = sample_i[SampleBits-1] ? PW'(-$signed({sample_i[SampleBits-1], sample_i}))
                                      : PW'({sample_i[SampleBits-1], sample_i});
  assign w_c = (a_c > peak_q) ? ((cfg_i.attack > drp_pkg::OneQ16) ? drp_pkg::OneQ16 : cfg_i.attack)
             : ((cfg_i.release_c > drp_pkg::OneQ16) ? drp_pkg::OneQ16 : cfg_i.release_c);
  assign full_o = (state_q != drp_pkg::FS_IDLE);
  assign peak_d = PW'((pa_q + pb_q + (PW+17)'(32768)) >> 16);

  always_comb begin
    e_c = '0;
    for (int i = 0; i < PW; i++) begin
      if (peak_q[i]) e_c = EW'(i);
    end
  end

  assign sq  = m_q * m_q;
  assign msq = 17'(sq >> 15);
  assign neg = (EW+17)'((SampleBits - 1 - int'(e_q))) * (EW+17)'(65536) - (EW+17)'(frac_q);
  assign prod = (EW+16+21)'(neg) * (EW+16+21)'(394566);
  assign dbm  = (prod + (EW+16+21)'(1 << 23)) >> 24;

  always_comb begin
    state_d = state_q;
    case (state_q)
      drp_pkg::FS_IDLE:     if (push_i) state_d = drp_pkg::FS_PEAK_MUL;
      drp_pkg::FS_PEAK_MUL: state_d = drp_pkg::FS_PEAK_SUM;
      drp_pkg::FS_PEAK_SUM: state_d = drp_pkg::FS_NORM;
      drp_pkg::FS_NORM:     state_d = (peak_q == '0) ? drp_pkg::FS_DB : drp_pkg::FS_LOG;
      drp_pkg::FS_LOG:      if (it_q == 5'd15) state_d = drp_pkg::FS_DB;
      drp_pkg::FS_DB:       state_d = drp_pkg::FS_PUSH;
      drp_pkg::FS_PUSH:     if (q_ready_i) state_d = drp_pkg::FS_IDLE;
      default:              state_d = drp_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drp_pkg::FS_IDLE;
      peak_q  <= PW'(1) << (SampleBits - 1);
    end else begin
      state_q <= state_d;
      if (state_q == drp_pkg::FS_PEAK_SUM) peak_q <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      drp_pkg::FS_IDLE: begin
        x_q <= sample_i;
        a_q <= a_c;
        w_q <= w_c;
      end
      drp_pkg::FS_PEAK_MUL: begin
        pa_q <= (PW+17)'(w_q) * (PW+17)'(a_q);
        pb_q <= (PW+17)'(drp_pkg::OneQ16 - w_q) * (PW+17)'(peak_q);
      end
      drp_pkg::FS_NORM: begin
        e_q <= e_c;
        m_q <= (e_c >= EW'(15)) ? 17'(peak_q >> (e_c - EW'(15)))
                                : 17'(peak_q << (EW'(15) - e_c));
        frac_q <= '0;
        it_q <= '0;
      end
      drp_pkg::FS_LOG: begin
        it_q <= it_q + 5'd1;
        frac_q <= {frac_q[14:0], msq[16]};
        m_q <= msq[16] ? (msq >> 1) : msq;
      end
      drp_pkg::FS_DB: begin
        if (peak_q == '0 || dbm > (EW+16+21)'(32768)) lvl_q <= -16'sd32768;
        else lvl_q <= 16'(-$signed({1'b0, 16'(dbm)}));
      end
      default: ;
    endcase
  end

  assign q_valid_o  = (state_q == drp_pkg::FS_PUSH);
  assign q_sample_o = x_q;
  assign q_level_o  = lvl_q;
endmodule

[rtl/core/drp_queue.sv]
`timescale 1ns / 1ps
`include "dynamic_range_processor_defines.svh"
// Two-entry queue between front and back.
module drp_queue #(
  parameter int Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);
  logic [Width-1:0] mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  `DRP_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= 2'd2, "queue count out of range")
  `DRP_ASSERT_IMP(a_ptr_match, clk_i, rst_ni, cnt_q != 2'd1, wp_q == rp_q, "queue pointers disagree")
  `DRP_ASSERT_NEXT(a_fill, clk_i, rst_ni, wr && !rd, cnt_q == $past(cnt_q) + 2'd1, "queue fill lost")
endmodule

[rtl/core/drp_back.sv]
`timescale 1ns / 1ps
`include "dynamic_range_processor_defines.svh"
// Gain computer, smoother and output stage.
module drp_back #(
  parameter int SampleBits = drp_pkg::SampleBits,
  parameter int SmoothTaps = drp_pkg::SmoothTaps
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  drp_pkg::cfg_t                cfg_i,
  input  logic                         q_valid_i,
  output logic                         q_ready_o,
  input  logic signed [SampleBits-1:0] q_sample_i,
  input  logic signed [15:0]           q_level_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic signed [SampleBits-1:0] sample_out_o
);
  localparam int PtrW = $clog2(SmoothTaps);
  localparam int SumW = 17 + $clog2(SmoothTaps + 1);
  localparam int QW   = SumW - $clog2(SmoothTaps) + 1;
  localparam int PW   = SampleBits + QW + 1;
  // reciprocal of the tap count, exact for every sum that fits SumW bits
  localparam int DivK = SumW + $clog2(SmoothTaps);
  localparam int RecW = SumW + 1;
  localparam logic [RecW-1:0] DivRecip =
    RecW'(((64'd1 << DivK) + 64'(SmoothTaps) - 64'd1) / 64'(SmoothTaps));

  drp_pkg::back_state_e state_q, state_d;
  logic signed [SampleBits-1:0] x_q;
  logic signed [15:0] lvl_q;
  logic [16:0] mem_q [SmoothTaps];
  logic [SmoothTaps-1:0] vld_q;
  logic [PtrW-1:0] ptr_q;
  logic [SumW-1:0] sum_q, rem_q;
  logic [QW-1:0] s_q;
  logic [16:0] old_q, g_q;
  logic mute_q, zmul_q, zero_q;
  logic signed [17:0] zdiff_q;
  logic signed [15:0] zslope_q;
  logic signed [33:0] zprod_q;
  logic signed [17:0] gdb_q;
  logic [17:0] t_q;
  logic [4:0] n_q;
  logic [15:0] f_q;
  logic signed [PW-1:0] y_q;
  logic signed [SampleBits-1:0] out_q;
  logic full_q;

  logic [33:0] zmag;
  logic [21:0] zr;
  logic [16:0] t0, t1;
  logic [29:0] dprod;
  logic [16:0] mi;
  logic [PW-1:0] ymag;
  logic [PW-17:0] yr;
  logic signed [PW-16:0] ys;
  logic [SumW+RecW-1:0] qprod;
  logic res_load;
  logic in_expand, in_compress;

  assign zmag = zprod_q[33] ? 34'(-zprod_q) : 34'(zprod_q);
  assign zr   = 22'((zmag + 34'd2048) >> 12);
  assign t0   = drp_pkg::exp2_tab({1'b0, f_q[15:12]});
  assign t1   = drp_pkg::exp2_tab(5'({1'b0, f_q[15:12]} + 5'd1));
  assign dprod = 30'(t0 - t1) * 30'(f_q[11:0]);
  assign mi   = t0 - 17'((dprod + 30'd2048) >> 12);
  assign ymag = y_q[PW-1] ? PW'(-y_q) : PW'(y_q);
  assign yr   = (PW-16)'((ymag + PW'(32768)) >> 16);
  assign ys   = y_q[PW-1] ? -$signed({1'b0, yr}) : $signed({1'b0, yr});
  assign qprod = (SumW+RecW)'(rem_q) * (SumW+RecW)'(DivRecip);
  assign in_expand = (lvl_q < cfg_i.expand_th) && (lvl_q >= cfg_i.gate_th);
  assign in_compress = (lvl_q < cfg_i.limit_th) && (lvl_q >= cfg_i.compress_th);
  // hold the finished result until the slot frees up
  assign res_load = (state_q == drp_pkg::BS_OUT_RND) && (!full_q || pop_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      drp_pkg::BS_IDLE:     if (q_valid_i) state_d = drp_pkg::BS_ZONE;
      drp_pkg::BS_ZONE:     state_d = drp_pkg::BS_ZMUL;
      drp_pkg::BS_ZMUL:     state_d = drp_pkg::BS_OCT;
      drp_pkg::BS_OCT:      state_d = drp_pkg::BS_INTERP;
      drp_pkg::BS_INTERP:   state_d = drp_pkg::BS_LIN;
      drp_pkg::BS_LIN:      state_d = drp_pkg::BS_HIST_RD;
      drp_pkg::BS_HIST_RD:  state_d = drp_pkg::BS_HIST_UPD;
      drp_pkg::BS_HIST_UPD: state_d = drp_pkg::BS_DIV;
      drp_pkg::BS_DIV:      state_d = drp_pkg::BS_OUT_MUL;
      drp_pkg::BS_OUT_MUL:  state_d = drp_pkg::BS_OUT_RND;
      drp_pkg::BS_OUT_RND:  if (!full_q || pop_i) state_d = drp_pkg::BS_IDLE;
      default:              state_d = drp_pkg::BS_IDLE;
    endcase
  end

  assign q_ready_o = (state_q == drp_pkg::BS_IDLE);
  assign empty_o = !full_q;
  assign sample_out_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drp_pkg::BS_IDLE;
      vld_q <= '0;
      ptr_q <= '0;
      sum_q <= '0;
      full_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == drp_pkg::BS_HIST_UPD) begin
        vld_q[ptr_q] <= 1'b1;
        sum_q <= sum_q + SumW'(g_q) - SumW'(old_q);
        ptr_q <= (ptr_q == PtrW'(SmoothTaps - 1)) ? '0 : ptr_q + PtrW'(1);
      end
      if (res_load) full_q <= 1'b1;
      else if (pop_i && full_q) full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == drp_pkg::BS_HIST_RD) old_q <= vld_q[ptr_q] ? mem_q[ptr_q] : 17'd0;
    if (state_q == drp_pkg::BS_HIST_UPD) mem_q[ptr_q] <= g_q;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      drp_pkg::BS_IDLE: begin
        x_q <= q_sample_i;
        lvl_q <= q_level_i;
      end
      drp_pkg::BS_ZONE: begin
        mute_q <= 1'b0;
        zmul_q <= 1'b0;
        zero_q <= 1'b0;
        zdiff_q <= '0;
        zslope_q <= '0;
        if ((lvl_q < cfg_i.compress_th) && (lvl_q >= cfg_i.expand_th)) zero_q <= 1'b1;
        else if (lvl_q < cfg_i.gate_th) mute_q <= 1'b1;
        else if (in_expand) begin
          zmul_q <= 1'b1;
          zslope_q <= cfg_i.expand_slope;
          zdiff_q <= 18'(cfg_i.expand_th) - 18'(lvl_q);
        end else if (in_compress) begin
          zmul_q <= 1'b1;
          zslope_q <= cfg_i.compress_slope;
          zdiff_q <= 18'(cfg_i.compress_th) - 18'(lvl_q);
        end else begin
          zdiff_q <= 18'(cfg_i.limit_th) - 18'(lvl_q);
        end
      end
      drp_pkg::BS_ZMUL: begin
        zprod_q <= 34'(zslope_q) * 34'(zdiff_q);
        gdb_q <= zero_q ? 18'sd0 : zdiff_q;
      end
      drp_pkg::BS_OCT: begin
        logic signed [20:0] gg;
        gg = zmul_q ? (zprod_q[33] ? -$signed({1'b0, zr[19:0]})
                                   : $signed({1'b0, zr[19:0]}))
                    : 21'(gdb_q);
        // any attenuation this deep already maps to a zero gain
        if (gg > 0) t_q <= 18'd0;
        else if (gg < -21'sd131071) t_q <= 18'd131071;
        else t_q <= 18'(-gg);
      end
      drp_pkg::BS_INTERP: begin
        logic [35:0] uu;
        uu = (36'(t_q) * 36'd174165 + 36'd2048) >> 12;
        n_q <= (uu[35:16] >= 20'd17) ? 5'd17 : 5'(uu[35:16]);
        f_q <= uu[15:0];
      end
      drp_pkg::BS_LIN: begin
        if (mute_q || n_q >= 5'd17) g_q <= 17'd0;
        else if (n_q == 5'd0) g_q <= mi;
        else g_q <= 17'((18'(mi) + (18'd1 << (n_q - 5'd1))) >> n_q);
      end
      drp_pkg::BS_HIST_UPD: begin
        rem_q <= sum_q + SumW'(g_q) - SumW'(old_q) + SumW'(SmoothTaps / 2);
      end
      drp_pkg::BS_DIV: s_q <= QW'(qprod >> DivK);
      drp_pkg::BS_OUT_MUL: y_q <= PW'(x_q) * $signed(PW'(s_q));
      drp_pkg::BS_OUT_RND: begin
        if (res_load) begin
          if (ys > $signed((PW-15)'((1 << (SampleBits - 1)) - 1)))
            out_q <= SampleBits'((1 << (SampleBits - 1)) - 1);
          else if (ys < -$signed((PW-15)'(1 << (SampleBits - 1))))
            out_q <= SampleBits'(-(1 << (SampleBits - 1)));
          else out_q <= SampleBits'(ys);
        end
      end
      default: ;
    endcase
  end

  `DRP_ASSERT_NEXT(a_out_full, clk_i, rst_ni, res_load, full_q, "result not held")
  `DRP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, full_q && !pop_i, full_q && $stable(out_q), "waiting result changed")
  `DRP_ASSERT_IMP(a_ptr, clk_i, rst_ni, 1'b1, {1'b0, ptr_q} < (PtrW+1)'(SmoothTaps), "history pointer out of range")
endmodule
